[hdl/assert_macros.svh]
// Assertion macros used by the cache RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define AST_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked property that is also checked during reset.
`define AST_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/sawbc_pkg.sv]
// Types and constants for the set-associative write-back cache.
`default_nettype none
package sawbc_pkg;

	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_LOOK  = 7'b0000100,
		S_WB    = 7'b0001000,
		S_FILL  = 7'b0010000,
		S_ISSUE = 7'b0100000,
		S_ACC   = 7'b1000000
	} state_t;

	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	// One Galois step, shift right, taps applied when the dropped bit is set.
	function automatic logic [15:0] lfsr_next(input logic [15:0] v);
		logic [15:0] r;
		r = v >> 1;
		if (v[0]) begin
			r = r ^ LFSR_TAPS;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hdl/set_assoc_write_back_cache.sv]
// Set-associative write-back cache with its backing word memory.
//
// channel | signals                                   | direction
// in      | in_valid, in_stall, mode, address,        | request beat into the block
//         | write_data, write_mask                    |
// out     | out_valid, out_stall, read_data, hit,     | one result beat per request
//         | wrote_back, way                           |
// cfg     | cfg_valid, cfg_ready, cfg_data            | replacement seed write
//
// Hit: tag row read on accept, then data read, then result register;
// the next request can be taken in the same cycle that the result is shown.
// Clean miss: the line is filled from the backing memory, then the word is accessed;
// a dirty victim is first written back to the backing memory, before the fill.
// After reset a clearing pass zeroes all 2^(ADDR_BITS-2) words of the backing memory
// (65536 at default), with in_stall held high.
// One request at a time; a result waiting on out_stall holds only the final step.
`default_nettype none
`include "assert_macros.svh"
module set_assoc_write_back_cache #(
	parameter int BLOCK_BITS = 6,
	parameter int WAY_BITS   = 2,
	parameter int CACHE_BITS = 14,
	parameter int ADDR_BITS  = 18
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 mode,
	input  wire logic [ADDR_BITS-1:0] address,
	input  wire logic [31:0]          write_data,
	input  wire logic [31:0]          write_mask,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [31:0]               read_data,
	output logic                      hit,
	output logic                      wrote_back,
	output logic [1:0]                way,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [15:0]          cfg_data
);

	localparam int SET_BITS  = CACHE_BITS - BLOCK_BITS - WAY_BITS;
	localparam int TAG_BITS  = ADDR_BITS - BLOCK_BITS - SET_BITS;
	localparam int LWB       = BLOCK_BITS - 2;
	localparam int LINE_BITS = CACHE_BITS - BLOCK_BITS;
	localparam int CW_BITS   = CACHE_BITS - 2;
	localparam int MW_BITS   = ADDR_BITS - 2;
	localparam int NUM_WAYS  = 1 << WAY_BITS;
	localparam int NUM_SETS  = 1 << SET_BITS;
	localparam int NUM_LINES = 1 << LINE_BITS;
	localparam int WIDX      = (WAY_BITS > 0) ? WAY_BITS : 1;
	localparam int LINE_WORDS = 1 << LWB;

	typedef logic [NUM_WAYS*TAG_BITS-1:0] tag_row_t;

	// storage
	logic [31:0]   cache_mem [1 << CW_BITS];
	logic [31:0]   back_mem  [1 << MW_BITS];
	tag_row_t      tag_mem   [NUM_SETS];
	logic [NUM_LINES-1:0] valid_q;
	logic [NUM_LINES-1:0] dirty_q;

	sawbc_pkg::state_t state_q;
	logic [15:0]          lfsr_q;
	logic [MW_BITS:0]     clr_q;
	logic [LWB:0]         cnt_q;

	logic                 mode_q;
	logic [LWB-1:0]       word_q;
	logic [SET_BITS-1:0]  set_q;
	logic [TAG_BITS-1:0]  tag_q;
	logic [31:0]          wdata_q;
	logic [31:0]          wmask_q;
	logic [WIDX-1:0]      way_q;
	logic                 hit_q;
	logic                 wb_q;
	logic [TAG_BITS-1:0]  old_tag_q;
	tag_row_t             tag_row_q;
	logic [31:0]          cache_rd_q;
	logic [31:0]          back_rd_q;

	logic                 out_valid_q;
	logic [31:0]          read_data_q;
	logic                 hit_out_q;
	logic                 wb_out_q;
	logic [1:0]           way_out_q;

	logic                 in_take;
	logic                 out_free;
	logic [NUM_WAYS-1:0]  match;
	logic [NUM_WAYS-1:0]  invalid;
	logic                 any_hit;
	logic                 any_inv;
	logic [WIDX-1:0]      hit_way;
	logic [WIDX-1:0]      inv_way;
	logic [15:0]          lfsr_nx;
	logic [WIDX-1:0]      victim;
	logic [LINE_BITS-1:0] cur_line;
	logic [LINE_BITS-1:0] vic_line;
	logic [LWB-1:0]       cnt_lo;
	logic [LWB-1:0]       cnt_prev;
	logic [31:0]          merged;

	function automatic logic [LINE_BITS-1:0] line_of(input logic [SET_BITS-1:0] s,
			input logic [WIDX-1:0] w);
		return LINE_BITS'({s, w} >> (WIDX - WAY_BITS));
	endfunction

	assign in_take   = in_valid && (state_q == sawbc_pkg::S_IDLE);
	assign in_stall  = (state_q != sawbc_pkg::S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign cur_line = line_of(set_q, way_q);
	assign cnt_lo   = cnt_q[LWB-1:0];
	assign cnt_prev = LWB'(cnt_q - 1'b1);
	assign merged   = (wdata_q & wmask_q) | (cache_rd_q & ~wmask_q);
	assign lfsr_nx  = sawbc_pkg::lfsr_next(lfsr_q);

	// tag compare and victim choice over the ways of the set
	always_comb begin
		match   = '0;
		invalid = '0;
		any_hit = 1'b0;
		any_inv = 1'b0;
		hit_way = '0;
		inv_way = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			invalid[w] = !valid_q[line_of(set_q, WIDX'(w))];
			match[w]   = !invalid[w] && (tag_row_q[w*TAG_BITS +: TAG_BITS] == tag_q);
		end
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				any_hit = 1'b1;
				hit_way = WIDX'(w);
			end
			if (invalid[w]) begin
				any_inv = 1'b1;
				inv_way = WIDX'(w);
			end
		end
		victim = any_inv ? inv_way : WIDX'(lfsr_nx & 16'(NUM_WAYS - 1));
	end

	assign vic_line = line_of(set_q, victim);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sawbc_pkg::S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			lfsr_q      <= 16'd1;
			valid_q     <= '0;
			dirty_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == sawbc_pkg::S_ACC && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// load the seed on a cfg write, else advance the LFSR on a miss with every way of the set valid
			if (cfg_valid && cfg_ready) begin
				lfsr_q <= cfg_data;
			end else if (state_q == sawbc_pkg::S_LOOK && !any_hit && !any_inv) begin
				lfsr_q <= lfsr_nx;
			end
			unique case (state_q)
				sawbc_pkg::S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (MW_BITS+1)'((1 << MW_BITS) - 1)) begin
						state_q <= sawbc_pkg::S_IDLE;
					end
				end
				sawbc_pkg::S_IDLE: begin
					if (in_take) begin
						state_q <= sawbc_pkg::S_LOOK;
					end
				end
				sawbc_pkg::S_LOOK: begin
					cnt_q <= '0;
					if (any_hit) begin
						state_q <= sawbc_pkg::S_ACC;
					end else begin
						if (valid_q[vic_line] && dirty_q[vic_line]) begin
							state_q <= sawbc_pkg::S_WB;
						end else begin
							state_q <= sawbc_pkg::S_FILL;
						end
					end
				end
				sawbc_pkg::S_WB: begin
					if (cnt_q == (LWB+1)'(LINE_WORDS)) begin
						cnt_q   <= '0;
						state_q <= sawbc_pkg::S_FILL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				sawbc_pkg::S_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (LWB+1)'(LINE_WORDS)) begin
						valid_q[cur_line] <= 1'b1;
						dirty_q[cur_line] <= 1'b0;
						state_q <= sawbc_pkg::S_ISSUE;
					end
				end
				sawbc_pkg::S_ISSUE: begin
					state_q <= sawbc_pkg::S_ACC;
				end
				sawbc_pkg::S_ACC: begin
					if (out_free) begin
						if (mode_q == sawbc_pkg::MODE_WRITE) begin
							dirty_q[cur_line] <= 1'b1;
						end
						state_q <= sawbc_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= sawbc_pkg::S_IDLE;
				end
			endcase
		end
	end

	// request and per-access registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_q  <= mode;
			word_q  <= address[BLOCK_BITS-1:2];
			set_q   <= address[BLOCK_BITS+SET_BITS-1:BLOCK_BITS];
			tag_q   <= address[ADDR_BITS-1:BLOCK_BITS+SET_BITS];
			wdata_q <= write_data;
			wmask_q <= write_mask;
		end
		if (state_q == sawbc_pkg::S_LOOK) begin
			hit_q     <= any_hit;
			way_q     <= any_hit ? hit_way : victim;
			wb_q      <= !any_hit && valid_q[vic_line] && dirty_q[vic_line];
			old_tag_q <= tag_row_q[victim*TAG_BITS +: TAG_BITS];
		end
		if (state_q == sawbc_pkg::S_ACC && out_free) begin
			read_data_q <= (mode_q == sawbc_pkg::MODE_WRITE) ? 32'd0 : cache_rd_q;
			hit_out_q   <= hit_q;
			wb_out_q    <= wb_q;
			way_out_q   <= 2'(way_q);
		end
	end

	// tag memory: row per set, read on accept, rewritten at end of fill
	always_ff @(posedge clk) begin
		if (in_take) begin
			tag_row_q <= tag_mem[address[BLOCK_BITS+SET_BITS-1:BLOCK_BITS]];
		end
		if (state_q == sawbc_pkg::S_FILL && cnt_q == (LWB+1)'(LINE_WORDS)) begin
			tag_mem[set_q] <= (tag_row_q & ~(tag_row_t'({TAG_BITS{1'b1}}) << (way_q*TAG_BITS)))
				| (tag_row_t'(tag_q) << (way_q*TAG_BITS));
		end
	end

	// cache data memory
	always_ff @(posedge clk) begin
		if (state_q == sawbc_pkg::S_LOOK) begin
			cache_rd_q <= cache_mem[{line_of(set_q, hit_way), word_q}];
		end else if (state_q == sawbc_pkg::S_ISSUE) begin
			cache_rd_q <= cache_mem[{cur_line, word_q}];
		end else if (state_q == sawbc_pkg::S_WB) begin
			cache_rd_q <= cache_mem[{cur_line, cnt_lo}];
		end
		if (state_q == sawbc_pkg::S_FILL && cnt_q != '0) begin
			cache_mem[{cur_line, cnt_prev}] <= back_rd_q;
		end else if (state_q == sawbc_pkg::S_ACC && out_free &&
				mode_q == sawbc_pkg::MODE_WRITE) begin
			cache_mem[{cur_line, word_q}] <= merged;
		end
	end

	// backing memory
	always_ff @(posedge clk) begin
		if (state_q == sawbc_pkg::S_FILL) begin
			back_rd_q <= back_mem[{tag_q, set_q, cnt_lo}];
		end
		if (state_q == sawbc_pkg::S_CLEAR) begin
			back_mem[clr_q[MW_BITS-1:0]] <= 32'd0;
		end else if (state_q == sawbc_pkg::S_WB && cnt_q != '0) begin
			back_mem[{old_tag_q, set_q, cnt_prev}] <= cache_rd_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign hit        = hit_out_q;
	assign wrote_back = wb_out_q;
	assign way        = way_out_q;

	`AST_CLK(a_result_from_acc, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == sawbc_pkg::S_ACC), "result without access step")
	`AST_CLK(a_hit_no_wb, clk, arst_n, out_valid_q |-> !(hit_out_q && wb_out_q), "write-back reported on a hit")
	`AST_ALWAYS(a_no_result_in_clear, clk, (state_q == sawbc_pkg::S_CLEAR) |-> !out_valid_q, "result during clearing pass")

endmodule
`default_nettype wire

[bench/set_assoc_write_back_cache_tb.sv]
// Self-checking testbench for the set-associative write-back cache.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_write_back_cache_tb;

	typedef struct packed {
		logic [31:0] read_data;
		logic        hit;
		logic        wrote_back;
		logic [1:0]  way;
	} access_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        mode = sawbc_pkg::MODE_READ;
	logic [17:0] address = '0;
	logic [31:0] write_data = '0;
	logic [31:0] write_mask = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] read_data;
	logic        hit;
	logic        wrote_back;
	logic [1:0]  way;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	// shadow copy of the cache and its backing memory
	logic [31:0] shadow_words [4096];
	logic [5:0]  shadow_tags [256];
	logic        shadow_valid [256];
	logic        shadow_dirty [256];
	logic [31:0] shadow_mem [65536];
	logic [15:0] shadow_lfsr;

	access_result_t pending_results [$];
	bit  idle_on = 1'b1;
	int  errors = 0;
	int  n_sent = 0;
	int  n_checked = 0;
	int  n_hits = 0;
	int  n_writebacks = 0;

	set_assoc_write_back_cache i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .address(address), .write_data(write_data), .write_mask(write_mask),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_data(read_data), .hit(hit), .wrote_back(wrote_back), .way(way),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	task automatic predict_access(input logic wr, input logic [17:0] a,
			input logic [31:0] wd, input logic [31:0] wm);
		logic [3:0]  word_sel;
		logic [5:0]  set_sel;
		logic [5:0]  tag_sel;
		logic [7:0]  base;
		logic [7:0]  ln;
		logic [1:0]  w_sel;
		logic [15:0] nx;
		bit          found;
		access_result_t r;
		word_sel = a[5:2];
		set_sel = a[11:6];
		tag_sel = a[17:12];
		base = {set_sel, 2'b00};
		found = 1'b0;
		w_sel = '0;
		r = '0;
		for (int i = 0; i < 4; i++) begin
			if (!found && shadow_valid[base + i] && shadow_tags[base + i] == tag_sel) begin
				found = 1'b1;
				w_sel = i[1:0];
			end
		end
		r.hit = found;
		if (!found) begin
			for (int i = 3; i >= 0; i--) begin
				if (!shadow_valid[base + i]) begin
					found = 1'b1;
					w_sel = i[1:0];
				end
			end
			if (!found) begin
				nx = shadow_lfsr >> 1;
				if (shadow_lfsr[0]) begin
					nx = nx ^ sawbc_pkg::LFSR_TAPS;
				end
				shadow_lfsr = nx;
				w_sel = nx[1:0];
			end
			ln = base + w_sel;
			if (shadow_valid[ln] && shadow_dirty[ln]) begin
				for (int w = 0; w < 16; w++) begin
					shadow_mem[{shadow_tags[ln], set_sel, w[3:0]}] = shadow_words[{ln, w[3:0]}];
				end
				r.wrote_back = 1'b1;
			end
			for (int w = 0; w < 16; w++) begin
				shadow_words[{ln, w[3:0]}] = shadow_mem[{a[17:6], w[3:0]}];
			end
			shadow_tags[ln] = tag_sel;
			shadow_valid[ln] = 1'b1;
			shadow_dirty[ln] = 1'b0;
		end
		ln = base + w_sel;
		if (wr == sawbc_pkg::MODE_WRITE) begin
			shadow_words[{ln, word_sel}] = (wd & wm) | (shadow_words[{ln, word_sel}] & ~wm);
			shadow_dirty[ln] = 1'b1;
		end else begin
			r.read_data = shadow_words[{ln, word_sel}];
		end
		r.way = w_sel;
		pending_results.push_back(r);
	endtask

	task automatic send_access(input logic wr, input logic [17:0] a,
			input logic [31:0] wd, input logic [31:0] wm);
		if (idle_on) begin
			while ($urandom_range(0, 99) < 35) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		mode <= wr;
		address <= a;
		write_data <= wd;
		write_mask <= wm;
		predict_access(wr, a, wd, wm);
		n_sent++;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_seed(input logic [15:0] seed);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= seed;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		shadow_lfsr = seed;
		@(posedge clk);
	endtask

	// compare every result beat against the oldest prediction
	always @(posedge clk) begin
		access_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_checked++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat rd=%h hit=%b wb=%b way=%0d",
					$time, read_data, hit, wrote_back, way);
			end else begin
				e = pending_results.pop_front();
				if (e.hit) n_hits++;
				if (e.wrote_back) n_writebacks++;
				if (read_data !== e.read_data) begin
					errors++;
					$display("%0t: read_data expected %h got %h", $time, e.read_data, read_data);
				end
				if (hit !== e.hit) begin
					errors++;
					$display("%0t: hit expected %b got %b", $time, e.hit, hit);
				end
				if (wrote_back !== e.wrote_back) begin
					errors++;
					$display("%0t: wrote_back expected %b got %b", $time, e.wrote_back, wrote_back);
				end
				if (way !== e.way) begin
					errors++;
					$display("%0t: way expected %0d got %0d", $time, e.way, way);
				end
			end
		end
		out_stall <= idle_on && ($urandom_range(0, 99) < 35);
	end

	task automatic test_directed;
		send_access(sawbc_pkg::MODE_READ, 18'h00000, '0, '0);
		send_access(sawbc_pkg::MODE_WRITE, 18'h3FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_access(sawbc_pkg::MODE_READ, 18'h3FFFC, '0, '0);
		send_access(sawbc_pkg::MODE_WRITE, 18'h3FFFD, 32'h1234_5678, 32'h0000_0000);
		send_access(sawbc_pkg::MODE_WRITE, 18'h3FFFE, 32'h0000_0000, 32'hF0F0_F0F0);
		send_access(sawbc_pkg::MODE_READ, 18'h3FFFF, '0, '0);
		// six tags into set 0: fills, then random victims with dirty write-back
		for (int t = 0; t < 6; t++) begin
			send_access(sawbc_pkg::MODE_WRITE, {t[5:0], 6'd0, 4'd3, 2'd0},
				32'hA5A5_0000 | t, 32'hFFFF_FFFF);
		end
		for (int t = 0; t < 6; t++) begin
			send_access(sawbc_pkg::MODE_READ, {t[5:0], 6'd0, 4'd3, 2'd1}, '0, '0);
		end
	endtask

	task automatic test_seed_extremes;
		logic [15:0] seeds [3];
		seeds = '{16'h0000, 16'hFFFF, 16'h0001};
		foreach (seeds[i]) begin
			write_seed(seeds[i]);
			// hammer set 63 with random tags so the LFSR picks the victims once its ways are full
			for (int k = 0; k < 8; k++) begin
				send_access(1'($urandom_range(0, 1)),
					{6'($urandom), 6'd63, 4'($urandom), 2'($urandom)},
					$urandom, $urandom);
			end
		end
	endtask

	task automatic test_random;
		logic [5:0]  hot_sets [3];
		logic [17:0] a;
		logic [31:0] m;
		for (int n = 0; n < 1900; n++) begin
			if (n % 500 == 250) begin
				write_seed(16'($urandom_range(1, 65535)));
			end
			idle_on = !(n >= 700 && n < 1000);
			if (n % 100 == 0) begin
				foreach (hot_sets[i]) hot_sets[i] = 6'($urandom);
			end
			a = 18'($urandom);
			if ($urandom_range(0, 99) < 80) begin
				a[11:6] = hot_sets[2'($urandom_range(0, 2))];
				a[17:12] = 6'($urandom_range(0, 9));
			end
			case ($urandom_range(0, 3))
				0: m = 32'hFFFF_FFFF;
				1: m = '0;
				default: m = $urandom;
			endcase
			send_access(1'($urandom_range(0, 1)), a, $urandom, m);
		end
		idle_on = 1'b1;
	endtask

	initial begin
		for (int i = 0; i < 256; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_dirty[i] = 1'b0;
			shadow_tags[i] = '0;
		end
		for (int i = 0; i < 4096; i++) shadow_words[i] = '0;
		for (int i = 0; i < 65536; i++) shadow_mem[i] = '0;
		shadow_lfsr = 16'h0001;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_seed_extremes();
		test_random();
		drain();
		$display("Sent %0d accesses, checked %0d results: %0d hits, %0d write-backs.",
			n_sent, n_checked, n_hits, n_writebacks);
		$display("Seeds covered zero, all ones, reset value and random values.");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, pending_results.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("Timeout with %0d results outstanding", pending_results.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/sawbc_pkg.sv
hdl/set_assoc_write_back_cache.sv
bench/set_assoc_write_back_cache_tb.sv
